// ===== hdl/zwpd_pkg.sv =====
// ----------------------------------------------------------------------------
// zwpd_pkg
// Shared types and constants of the zero-width payload decoder.
// ----------------------------------------------------------------------------
package zwpd_pkg;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_START   = 3'd1;
  localparam logic [2:0] ST_NO_END     = 3'd2;
  localparam logic [2:0] ST_BAD_SYMBOL = 3'd3;
  localparam logic [2:0] ST_PARTIAL    = 3'd4;

  localparam logic [2:0] REG_SYM0   = 3'd0;
  localparam logic [2:0] REG_SYM1   = 3'd1;
  localparam logic [2:0] REG_SYM2   = 3'd2;
  localparam logic [2:0] REG_SYM3   = 3'd3;
  localparam logic [2:0] REG_MARKER = 3'd4;

  localparam logic [23:0] SYM0_RESET   = 24'hE2808B;
  localparam logic [23:0] SYM1_RESET   = 24'hE2808C;
  localparam logic [23:0] SYM2_RESET   = 24'hE2808D;
  localparam logic [23:0] SYM3_RESET   = 24'hEFBBBF;
  localparam logic [23:0] MARKER_RESET = 24'hE281A0;

  localparam logic [1:0] PH_SEARCH  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_ENDED   = 2'd2;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic       last_out;
  } result_t;

endpackage

// ===== hdl/zero_width_payload_decoder_core.sv =====
// ----------------------------------------------------------------------------
// zero_width_payload_decoder_core
// Results: each input transfer that causes a result writes it into the result queue.
// Throughput: one text byte per cycle while input is ready; a final byte that
// also completes a data byte leaves two results, drained one per cycle from a
// 4-entry queue while out_tready is high; input is ready with >= 2 entries free.
// Reset: synchronous, clears decode state, empties the queue, restores codes.
// ----------------------------------------------------------------------------
// Decodes a payload hidden as zero-width characters in a UTF-8 byte stream.
// ----------------------------------------------------------------------------
module zero_width_payload_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [10:8] status, [15:11] zero
  output logic        out_tuser,  // item_kind
  output logic        out_tlast,  // last_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [23:0] sym0_r, sym1_r, sym2_r, sym3_r, marker_r;

  logic [47:0] win_r, win_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  gpos_r, gpos_nxt;
  logic [1:0]  scnt_r, scnt_nxt;
  logic [5:0]  acc_r, acc_nxt;
  logic        mpend_r, mpend_nxt;
  logic [2:0]  fstat_r, fstat_nxt;

  zwpd_pkg::result_t q_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;

  logic              in_fire, out_fire;
  logic [47:0]       win_new;
  logic [23:0]       grp;
  logic              sym_hit;
  logic [1:0]        sym_val;
  logic              push_data, push_stat;
  logic [7:0]        data_val;
  logic [2:0]        stat_val;
  zwpd_pkg::result_t data_res, stat_res;
  logic [1:0]        stat_ptr;
  logic [2:0]        push_cnt;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (cnt_r <= 3'd2);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_fire   = out_tvalid && out_tready;

  assign out_tdata = {5'd0, q_r[rd_ptr_r].status, q_r[rd_ptr_r].data_byte};
  assign out_tuser = q_r[rd_ptr_r].item_kind;
  assign out_tlast = q_r[rd_ptr_r].last_out;

  assign win_new = {win_r[39:0], in_tdata};
  assign grp     = win_new[23:0];

  always_comb begin
    sym_hit = 1'b1;
    sym_val = 2'd0;
    if (grp == sym0_r) begin
      sym_val = 2'd0;
    end else if (grp == sym1_r) begin
      sym_val = 2'd1;
    end else if (grp == sym2_r) begin
      sym_val = 2'd2;
    end else if (grp == sym3_r) begin
      sym_val = 2'd3;
    end else begin
      sym_hit = 1'b0;
    end
  end

  always_comb begin
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    phase_nxt = phase_r;
    gpos_nxt  = gpos_r;
    scnt_nxt  = scnt_r;
    acc_nxt   = acc_r;
    mpend_nxt = mpend_r;
    fstat_nxt = fstat_r;
    push_data = 1'b0;
    data_val  = 8'd0;
    stat_val  = zwpd_pkg::ST_OK;

    unique case (phase_r)
      zwpd_pkg::PH_SEARCH: begin
        win_nxt = win_new;
        if (fill_r < 3'd6) begin
          fill_nxt = fill_r + 3'd1;
        end
        if (fill_r >= 3'd5 && win_new == {marker_r, marker_r}) begin
          phase_nxt = zwpd_pkg::PH_PAYLOAD;
          gpos_nxt  = 2'd0;
          scnt_nxt  = 2'd0;
          acc_nxt   = 6'd0;
          mpend_nxt = 1'b0;
        end
      end
      zwpd_pkg::PH_PAYLOAD: begin
        win_nxt = win_new;
        if (gpos_r == 2'd2) begin
          gpos_nxt = 2'd0;
          if (grp == marker_r) begin
            if (mpend_r) begin
              phase_nxt = zwpd_pkg::PH_ENDED;
              fstat_nxt = (scnt_r != 2'd0) ? zwpd_pkg::ST_PARTIAL : zwpd_pkg::ST_OK;
            end else begin
              mpend_nxt = 1'b1;
            end
          end else if (mpend_r || !sym_hit) begin
            phase_nxt = zwpd_pkg::PH_ENDED;
            fstat_nxt = zwpd_pkg::ST_BAD_SYMBOL;
          end else if (scnt_r == 2'd3) begin
            push_data = 1'b1;
            data_val  = {acc_r, sym_val};
            scnt_nxt  = 2'd0;
            acc_nxt   = 6'd0;
          end else begin
            acc_nxt  = {acc_r[3:0], sym_val};
            scnt_nxt = scnt_r + 2'd1;
          end
        end else begin
          gpos_nxt = gpos_r + 2'd1;
        end
      end
      default: begin
      end
    endcase

    push_stat = in_tlast;
    if (in_tlast) begin
      if (phase_nxt == zwpd_pkg::PH_SEARCH) begin
        stat_val = zwpd_pkg::ST_NO_START;
      end else if (phase_nxt == zwpd_pkg::PH_PAYLOAD) begin
        stat_val = zwpd_pkg::ST_NO_END;
      end else begin
        stat_val = fstat_nxt;
      end
      win_nxt   = 48'd0;
      fill_nxt  = 3'd0;
      phase_nxt = zwpd_pkg::PH_SEARCH;
      gpos_nxt  = 2'd0;
      scnt_nxt  = 2'd0;
      acc_nxt   = 6'd0;
      mpend_nxt = 1'b0;
      fstat_nxt = zwpd_pkg::ST_OK;
    end
  end

  always_comb begin
    data_res.item_kind = 1'b0;
    data_res.data_byte = data_val;
    data_res.status    = zwpd_pkg::ST_OK;
    data_res.last_out  = 1'b0;
    stat_res.item_kind = 1'b1;
    stat_res.data_byte = 8'd0;
    stat_res.status    = stat_val;
    stat_res.last_out  = 1'b1;
    stat_ptr = wr_ptr_r + {1'b0, push_data};
    push_cnt = in_fire ? ({2'd0, push_data} + {2'd0, push_stat}) : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym0_r   <= zwpd_pkg::SYM0_RESET;
      sym1_r   <= zwpd_pkg::SYM1_RESET;
      sym2_r   <= zwpd_pkg::SYM2_RESET;
      sym3_r   <= zwpd_pkg::SYM3_RESET;
      marker_r <= zwpd_pkg::MARKER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        zwpd_pkg::REG_SYM0:   sym0_r   <= cfg_data;
        zwpd_pkg::REG_SYM1:   sym1_r   <= cfg_data;
        zwpd_pkg::REG_SYM2:   sym2_r   <= cfg_data;
        zwpd_pkg::REG_SYM3:   sym3_r   <= cfg_data;
        zwpd_pkg::REG_MARKER: marker_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= 48'd0;
      fill_r  <= 3'd0;
      phase_r <= zwpd_pkg::PH_SEARCH;
      gpos_r  <= 2'd0;
      scnt_r  <= 2'd0;
      acc_r   <= 6'd0;
      mpend_r <= 1'b0;
      fstat_r <= zwpd_pkg::ST_OK;
    end else if (in_fire) begin
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      phase_r <= phase_nxt;
      gpos_r  <= gpos_nxt;
      scnt_r  <= scnt_nxt;
      acc_r   <= acc_nxt;
      mpend_r <= mpend_nxt;
      fstat_r <= fstat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && push_data) begin
      q_r[wr_ptr_r] <= data_res;
    end
    if (in_fire && push_stat) begin
      q_r[stat_ptr] <= stat_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_cnt[1:0];
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      cnt_r <= cnt_r + push_cnt - {2'd0, out_fire};
    end
  end

endmodule
